### design/sndw_pkg.sv
// ----------------------------------------------------------------------------
// sndw_pkg
// Shared types, constants and field helpers for the strided N-d address walker.
// ----------------------------------------------------------------------------
package sndw_pkg;

   localparam int MAX_AXES    = 3;
   localparam int EXTENT_BITS = 16;
   localparam int FIELD_BITS  = 16;
   localparam int PACK_AXES   = 3;
   localparam int PACK_BITS   = PACK_AXES * FIELD_BITS;
   localparam int OFFSET_BITS = 32;
   localparam int DIMS_BITS   = 2;
   localparam int CSR_BITS    = 3;
   localparam int PROD_BITS   = 48;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_DIMS_IN_USE    = 3'd0,
      CSR_EXTENTS        = 3'd1,
      CSR_SOURCE_STRIDES = 3'd2,
      CSR_DEST_STRIDES   = 3'd3,
      CSR_SOURCE_BASE    = 3'd4,
      CSR_DEST_BASE      = 3'd5
   } csr_index_type;

   typedef logic [EXTENT_BITS-1:0]               count_type;
   typedef logic [MAX_AXES-1:0][EXTENT_BITS-1:0] counts_type;
   typedef logic [PACK_BITS-1:0]                 packed_type;
   typedef logic [OFFSET_BITS-1:0]               offset_type;

   // current element as seen by the walker, before the odometer advance
   typedef struct packed {
      logic       has_result;
      logic       final_el;
      counts_type counts;
   } walk_elem_type;

   // load enables for the two datapath register ranks
   typedef struct packed {
      logic load_prod;
      logic load_sum;
   } pipe_ctl_type;

   // axis 0 sits in the high field
   function automatic logic [FIELD_BITS-1:0] field_of(input packed_type word, input int axis);
      int pos;
      pos = (PACK_AXES - 1 - (axis % PACK_AXES)) * FIELD_BITS;
      return word[pos +: FIELD_BITS];
   endfunction

   function automatic count_type extent_of(input packed_type word, input int axis);
      logic [FIELD_BITS-1:0] f;
      f = field_of(word, axis);
      return f[EXTENT_BITS-1:0];
   endfunction

endpackage

### design/sndw_walker.sv
// ----------------------------------------------------------------------------
// sndw_walker
// Odometer index counters: restart, unused-axis clearing, final flag, advance.
// ----------------------------------------------------------------------------
module sndw_walker import sndw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 restart,
   input  logic [DIMS_BITS-1:0] dims_in_use,
   input  packed_type           extents,
   output walk_elem_type        elem
);

   counts_type                  counters_ff;
   counts_type                  counters_in;
   counts_type                  cur;
   counts_type                  nxt;
   logic [MAX_AXES-1:0]         in_use;
   logic [DIMS_BITS-1:0]        dims_eff;
   logic                        any_zero;
   logic                        all_final;

   always_comb begin
      count_type ext;
      count_type inc;
      logic      carry;

      if (dims_in_use == '0) begin
         dims_eff = DIMS_BITS'(1);
      end else if (int'(dims_in_use) > MAX_AXES) begin
         dims_eff = DIMS_BITS'(MAX_AXES);
      end else begin
         dims_eff = dims_in_use;
      end

      any_zero  = 1'b0;
      all_final = 1'b1;
      for (int a = 0; a < MAX_AXES; a++) begin
         ext       = extent_of(extents, a);
         in_use[a] = (a + int'(dims_eff)) >= MAX_AXES;
         cur[a]    = (restart || !in_use[a]) ? '0 : counters_ff[a];
         if (in_use[a] && ext == '0) begin
            any_zero = 1'b1;
         end
         if (in_use[a] && cur[a] != count_type'(ext - 1'b1)) begin
            all_final = 1'b0;
         end
      end

      // last axis fastest; an out-of-range counter wraps and carries
      carry = 1'b1;
      for (int a = MAX_AXES - 1; a >= 0; a--) begin
         ext    = extent_of(extents, a);
         inc    = cur[a] + 1'b1;
         nxt[a] = cur[a];
         if (in_use[a] && carry) begin
            if (inc < ext && inc != '0) begin
               nxt[a] = inc;
               carry  = 1'b0;
            end else begin
               nxt[a] = '0;
            end
         end
      end

      counters_in = any_zero ? cur : nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counters_ff <= '0;
      end else if (accept) begin
         counters_ff <= counters_in;
      end
   end

   assign elem.has_result = !any_zero;
   assign elem.final_el   = all_final;
   assign elem.counts     = cur;

endmodule

### design/sndw_offset.sv
// ----------------------------------------------------------------------------
// sndw_offset
// Byte offset of one element: registered per-axis products, then base + sum.
// ----------------------------------------------------------------------------
module sndw_offset import sndw_pkg::*; (
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  counts_type   counts,
   input  packed_type   strides,
   input  offset_type   base,
   output offset_type   offset
);

   offset_type prod_ff [MAX_AXES];
   offset_type prod_in [MAX_AXES];
   offset_type sum_ff;
   offset_type sum_in;

   always_comb begin
      logic signed [PROD_BITS-1:0] full;
      for (int a = 0; a < MAX_AXES; a++) begin
         full       = $signed({1'b0, counts[a]}) * $signed(field_of(strides, a));
         prod_in[a] = full[OFFSET_BITS-1:0];
      end
   end

   always_comb begin
      sum_in = base;
      for (int a = 0; a < MAX_AXES; a++) begin
         sum_in = sum_in + prod_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         for (int a = 0; a < MAX_AXES; a++) begin
            prod_ff[a] <= prod_in[a];
         end
      end
      if (ctl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign offset = sum_ff;

endmodule

### design/strided_nd_address_walker.sv
// ----------------------------------------------------------------------------
// strided_nd_address_walker
// Row-major N-d index walker giving source/destination byte offset pairs.
// ----------------------------------------------------------------------------
// Each accepted request yields one word with the source and destination
// offsets of the current element (base plus index times stride, modulo 2^32)
// and a final-element flag, then steps the index; the walk wraps after the
// final element and req_restart returns it to the first. No word comes out
// while an axis in use has a zero extent. One request is taken per cycle while
// req_stall is low, passing three register ranks (counter snapshot, per-axis
// multiplies, base-plus-sum add). The user must write configuration registers
// only while no request is in flight; the block itself does not enforce it.
module strided_nd_address_walker import sndw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OFFSET_BITS-1:0] rsp_source_offset,
   output logic [OFFSET_BITS-1:0] rsp_dest_offset,
   output logic                   rsp_final_element,
   input  logic                   csr_wr_en,
   input  logic [CSR_BITS-1:0]    csr_index,
   input  logic [PACK_BITS-1:0]   csr_wr_data
);

   logic [DIMS_BITS-1:0] dims_ff;
   packed_type           extents_ff;
   packed_type           src_strides_ff;
   packed_type           dst_strides_ff;
   offset_type           src_base_ff;
   offset_type           dst_base_ff;

   walk_elem_type        elem;
   pipe_ctl_type         ctl;
   logic                 accept;
   logic                 s1_ready, s2_ready, s3_ready;
   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                 s1_final_ff, s2_final_ff, s3_final_ff;
   counts_type           s1_counts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff        <= DIMS_BITS'(1);
         extents_ff     <= PACK_BITS'(1);
         src_strides_ff <= '0;
         dst_strides_ff <= '0;
         src_base_ff    <= '0;
         dst_base_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIMS_IN_USE:    dims_ff        <= csr_wr_data[DIMS_BITS-1:0];
            CSR_EXTENTS:        extents_ff     <= csr_wr_data;
            CSR_SOURCE_STRIDES: src_strides_ff <= csr_wr_data;
            CSR_DEST_STRIDES:   dst_strides_ff <= csr_wr_data;
            CSR_SOURCE_BASE:    src_base_ff    <= csr_wr_data[OFFSET_BITS-1:0];
            CSR_DEST_BASE:      dst_base_ff    <= csr_wr_data[OFFSET_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // each rank advances when the one after it is empty or moving
   assign s3_ready  = !s3_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   assign ctl.load_prod = s2_ready && s1_valid_ff;
   assign ctl.load_sum  = s3_ready && s2_valid_ff;

   sndw_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .restart     (req_restart),
      .dims_in_use (dims_ff),
      .extents     (extents_ff),
      .elem        (elem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= accept && elem.has_result;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_counts_ff <= elem.counts;
         s1_final_ff  <= elem.final_el;
      end
      if (ctl.load_prod) begin
         s2_final_ff <= s1_final_ff;
      end
      if (ctl.load_sum) begin
         s3_final_ff <= s2_final_ff;
      end
   end

   sndw_offset u_src_offset (
      .clock   (clock),
      .ctl     (ctl),
      .counts  (s1_counts_ff),
      .strides (src_strides_ff),
      .base    (src_base_ff),
      .offset  (rsp_source_offset)
   );

   sndw_offset u_dst_offset (
      .clock   (clock),
      .ctl     (ctl),
      .counts  (s1_counts_ff),
      .strides (dst_strides_ff),
      .base    (dst_base_ff),
      .offset  (rsp_dest_offset)
   );

   assign rsp_valid         = s3_valid_ff;
   assign rsp_final_element = s3_final_ff;

endmodule
